// File: sv/psc_pkg.sv
package psc_pkg;

	localparam int SPEED_W  = 16;
	localparam int GAIN_W   = 24;
	localparam int DRIVE_W  = 24;
	localparam int ERR_W    = SPEED_W + 1;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int FRAC_W   = 16;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ERR_TOL      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MAX   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MIN   = 3'd6;

	localparam logic signed [DRIVE_W-1:0] OUTPUT_MAX_RESET = 24'sd65535;

endpackage

// File: sv/pid_speed_controller.sv
// Throughput: one sample per cycle unless the output stalls. The error sum,
// previous error and saturated flag feed back through a single pass of error, sum
// update, three multiplies and clamp. The output register lets a new sample enter
// speed_s1 while a result waits in m_tdata and m_tuser to be taken.
// Reset (arst_n low, asynchronous) clears the error sum, previous error and flag,
// empties both stages and loads the register defaults (output_max 65535, others 0).
module pid_speed_controller
	import psc_pkg::*;
#(
	parameter int SUM_WIDTH = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [GAIN_W-1:0]     wr_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [15:0] measured_speed
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [23:0] drive_value
	output logic [0:0]            m_tuser    // [0] saturated
);

	localparam int IPROD_W = SUM_WIDTH + GAIN_W;
	localparam int PPROD_W = GAIN_W + ERR_W;
	localparam int DPROD_W = GAIN_W + DIFF_W;
	localparam int ACC_W   = SUM_WIDTH + GAIN_W + 2;

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	// Configuration registers
	logic        [SPEED_W-1:0] target_speed_q;
	logic signed [GAIN_W-1:0]  prop_gain_q;
	logic signed [GAIN_W-1:0]  integ_gain_q;
	logic signed [GAIN_W-1:0]  deriv_gain_q;
	logic        [SPEED_W-1:0] err_tol_q;
	logic signed [DRIVE_W-1:0] output_max_q;
	logic signed [DRIVE_W-1:0] output_min_q;

	// Controller state
	logic signed [SUM_WIDTH-1:0] error_sum_q;
	logic signed [ERR_W-1:0]     last_err_q;
	logic                        sat_q;

	// Input stage and output register
	logic                 valid_s1;
	logic [SPEED_W-1:0]   speed_s1;
	logic                 advance;
	logic                 step;

	logic signed [ERR_W-1:0]     err;
	logic        [ERR_W-1:0]     err_mag;
	logic signed [DIFF_W-1:0]    err_diff;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_add;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [PPROD_W-1:0]   p_prop;
	logic signed [IPROD_W-1:0]   p_integ;
	logic signed [DPROD_W-1:0]   p_deriv;
	logic signed [ACC_W-1:0]     acc;
	logic signed [ACC_W-1:0]     acc_adj;
	logic signed [ACC_W-1:0]     acc_sh;
	logic signed [ACC_W-1:0]     max_ext;
	logic signed [ACC_W-1:0]     min_ext;
	logic signed [DRIVE_W-1:0]   drive;
	logic                        sat_next;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_speed_q <= '0;
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			err_tol_q      <= '0;
			output_max_q   <= OUTPUT_MAX_RESET;
			output_min_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TARGET_SPEED: target_speed_q <= wr_data[SPEED_W-1:0];
				REG_PROP_GAIN:    prop_gain_q    <= $signed(wr_data);
				REG_INTEG_GAIN:   integ_gain_q   <= $signed(wr_data);
				REG_DERIV_GAIN:   deriv_gain_q   <= $signed(wr_data);
				REG_ERR_TOL:      err_tol_q      <= wr_data[SPEED_W-1:0];
				REG_OUTPUT_MAX:   output_max_q   <= $signed(wr_data);
				REG_OUTPUT_MIN:   output_min_q   <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	// Error and conditional integration with a saturating sum.
	assign err      = $signed({1'b0, target_speed_q}) - $signed({1'b0, speed_s1});
	assign err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign err_diff = DIFF_W'(err) - DIFF_W'(last_err_q);
	assign sum_ext  = (SUM_WIDTH+1)'(error_sum_q) + (SUM_WIDTH+1)'(err);

	always_comb begin
		if (sum_ext[SUM_WIDTH] == sum_ext[SUM_WIDTH-1]) begin
			sum_add = sum_ext[SUM_WIDTH-1:0];
		end else if (sum_ext[SUM_WIDTH]) begin
			sum_add = SUM_MIN;
		end else begin
			sum_add = SUM_MAX;
		end
		if (target_speed_q == '0) begin
			sum_next = '0;
		end else if (err_mag > ERR_W'(err_tol_q) && !sat_q) begin
			sum_next = sum_add;
		end else begin
			sum_next = error_sum_q;
		end
	end

	assign p_prop  = prop_gain_q * err;
	assign p_integ = integ_gain_q * sum_next;
	assign p_deriv = deriv_gain_q * err_diff;
	assign acc     = ACC_W'(p_prop) + ACC_W'(p_integ) + ACC_W'(p_deriv);

	// Adding the fraction mask before the arithmetic shift rounds negatives toward zero.
	assign acc_adj = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
	assign acc_sh  = acc_adj >>> FRAC_W;
	assign max_ext = ACC_W'(output_max_q);
	assign min_ext = ACC_W'(output_min_q);

	// The upper limit wins when limits cross and sets the flag; the lower keeps it.
	always_comb begin
		if (acc_sh >= max_ext) begin
			drive    = output_max_q;
			sat_next = 1'b1;
		end else if (acc_sh <= min_ext) begin
			drive    = output_min_q;
			sat_next = sat_q;
		end else begin
			drive    = acc_sh[DRIVE_W-1:0];
			sat_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			m_tvalid    <= 1'b0;
			error_sum_q <= '0;
			last_err_q  <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_tvalid <= valid_s1;
			end
			if (step) begin
				error_sum_q <= sum_next;
				last_err_q  <= err;
				sat_q       <= sat_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			speed_s1 <= s_tdata[SPEED_W-1:0];
		end
		if (step) begin
			m_tdata    <= drive;
			m_tuser[0] <= sat_next;
		end
	end

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tready || !m_tvalid) |-> s_tready)
		else $error("input stalled although the output side can drain");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(error_sum_q) && $stable(last_err_q) && $stable(sat_q)))
		else $error("controller state changed without a sample step");

	a_zero_target_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && target_speed_q == '0) |=> (error_sum_q == '0))
		else $error("error sum not cleared for a zero target");

	a_drive_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && output_min_q <= output_max_q) |->
		($signed(m_tdata) >= output_min_q && $signed(m_tdata) <= output_max_q))
		else $error("drive value outside the output limits");

endmodule

// File: tb/tb.sv
module tb;
	import psc_pkg::*;

	localparam int SUM_W = 40;
	localparam longint SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam int STUCK_LIMIT = 4000;
	localparam int LONG_STALL = 400;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      sat;
	} drive_res_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [GAIN_W-1:0]     wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;
	logic [0:0]            m_tuser;

	pid_speed_controller #(.SUM_WIDTH(SUM_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Controller settings and loop state as the block should hold them.
	logic [15:0]               tgt = '0;
	logic signed [GAIN_W-1:0]  kp = '0, ki = '0, kd = '0;
	logic [15:0]               tol = '0;
	logic signed [DRIVE_W-1:0] omax = OUTPUT_MAX_RESET, omin = '0;
	longint                    err_sum = 0;
	logic signed [ERR_W:0]     prev_err = '0;
	logic                      sat = 1'b0;

	logic [15:0] speed_q[$];
	drive_res_t  expected_drive_q[$];
	drive_res_t  want;
	int          queued_cnt = 0;
	int          accepted_cnt = 0;
	int          mismatches = 0;
	int          stuck = 0;
	int          in_idle = 31;
	int          out_idle = 67;
	int          stall_left = 0;
	bit          stall_req = 1'b0;
	bit          in_sent = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic drive_res_t pid_tick(input logic [15:0] speed);
		logic signed [ERR_W:0]   e;
		logic signed [ERR_W+1:0] de;
		longint                  mag;
		longint                  nsum;
		logic signed [79:0]      acc;
		logic signed [79:0]      q;
		logic signed [79:0]      hi;
		logic signed [79:0]      lo;
		drive_res_t              r;
		e = $signed({2'b00, tgt}) - $signed({2'b00, speed});
		de = e - prev_err;
		mag = (e < 0) ? -longint'(e) : longint'(e);
		if (tgt == 0) begin
			err_sum = 0;
		end else if (mag > longint'(tol) && !sat) begin
			nsum = err_sum + longint'(e);
			if (nsum > SUM_MAX)
				nsum = SUM_MAX;
			else if (nsum < SUM_MIN)
				nsum = SUM_MIN;
			err_sum = nsum;
		end
		acc = kp * e + ki * err_sum + kd * de;
		// Shift toward zero, not toward minus infinity.
		q = (acc < 0) ? -((-acc) >>> FRAC_W) : (acc >>> FRAC_W);
		hi = omax;
		lo = omin;
		if (q >= hi) begin
			r.drive = omax;
			sat = 1'b1;
		end else if (q <= lo) begin
			r.drive = omin;
		end else begin
			r.drive = q[DRIVE_W-1:0];
			sat = 1'b0;
		end
		prev_err = e;
		r.sat = sat;
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_TARGET_SPEED: tgt = val[15:0];
			REG_PROP_GAIN:    kp = val;
			REG_INTEG_GAIN:   ki = val;
			REG_DERIV_GAIN:   kd = val;
			REG_ERR_TOL:      tol = val[15:0];
			REG_OUTPUT_MAX:   omax = val;
			REG_OUTPUT_MIN:   omin = val;
			default: ;
		endcase
	endtask

	task automatic program_loop(input logic [23:0] t, input logic [23:0] p, input logic [23:0] i,
			input logic [23:0] d, input logic [23:0] tl, input logic [23:0] hi,
			input logic [23:0] lo);
		write_reg(REG_TARGET_SPEED, t);
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_ERR_TOL, tl);
		write_reg(REG_OUTPUT_MAX, hi);
		write_reg(REG_OUTPUT_MIN, lo);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic offer(input logic [15:0] speed);
		speed_q.push_back(speed);
		queued_cnt++;
	endtask

	// The sender holds back until every sample has gone in and every result has come out.
	task automatic settle();
		while (accepted_cnt != queued_cnt)
			@(posedge clk);
		while (expected_drive_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_gain();
		case ($urandom_range(0, 6))
			0: return 24'd0;
			1: return 24'($urandom());
			2: return 24'h7FFFFF;
			3: return 24'h800000;
			default: return 24'(int'($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	task automatic random_phase();
		logic [15:0]        t;
		logic [15:0]        tl;
		logic signed [23:0] a;
		logic signed [23:0] b;
		logic signed [23:0] hi;
		logic signed [23:0] lo;
		int                 n;
		int                 r;
		int                 span;
		int                 s;
		case ($urandom_range(0, 4))
			0: t = 16'd0;
			1: t = 16'hFFFF;
			4: t = 16'($urandom_range(0, 100));
			default: t = 16'($urandom());
		endcase
		case ($urandom_range(0, 4))
			0: tl = 16'd0;
			1: tl = 16'hFFFF;
			4: tl = 16'($urandom());
			default: tl = 16'($urandom_range(0, 200));
		endcase
		case ($urandom_range(0, 4))
			0: begin
				hi = 24'sd65535;
				lo = 24'sd0;
			end
			1: begin
				hi = 24'h7FFFFF;
				lo = 24'h800000;
			end
			2: begin
				a = 24'($urandom());
				b = 24'($urandom());
				hi = (a > b) ? a : b;
				lo = (a > b) ? b : a;
			end
			3: begin
				// Crossed limits: the lower limit sits above the upper one.
				hi = 24'(-int'($urandom_range(0, 5000)));
				lo = 24'($urandom_range(1, 5000));
			end
			default: begin
				hi = 24'($urandom_range(0, 5000));
				lo = 24'(-int'($urandom_range(0, 5000)));
			end
		endcase
		program_loop({8'($urandom()), t}, pick_gain(), pick_gain(), pick_gain(),
			{8'($urandom()), tl}, hi, lo);
		n = $urandom_range(70, 100);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				span = (int'(tol) + 3 > 2000) ? 2000 : int'(tol) + 3;
				s = int'(tgt) + int'($urandom_range(0, 2 * span)) - span;
				s = (s < 0) ? 0 : ((s > 65535) ? 65535 : s);
				offer(16'(s));
			end else if (r < 85) begin
				offer(16'($urandom()));
			end else begin
				case ($urandom_range(0, 2))
					0: offer(16'd0);
					1: offer(16'hFFFF);
					default: offer(tgt);
				endcase
			end
		end
	endtask

	// Wind the error sum far upward, or with upward clear pull it back down hard.
	task automatic windup_phase(input bit upward);
		program_loop(upward ? 24'd65535 : 24'($urandom_range(1, 50)),
			24'($urandom_range(0, 16)), 24'($urandom_range(1, 16)),
			24'($urandom_range(0, 16)), 24'($urandom_range(0, 100)),
			24'h7FFFFF, 24'h800000);
		repeat (upward ? 150 : 300)
			offer(upward ? 16'($urandom_range(0, 50)) : 16'($urandom_range(65485, 65535)));
	endtask

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_sent)) begin
			if (speed_q.size() != 0 && $urandom_range(0, 99) >= in_idle) begin
				s_tdata <= speed_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (stall_req) begin
			stall_req = 1'b0;
			stall_left = LONG_STALL;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= out_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_sent = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (expected_drive_q.size() == 0) begin
					note_mismatch($sformatf("unexpected result drive %0d",
						$signed(m_tdata)));
				end else begin
					want = expected_drive_q.pop_front();
					if (m_tdata !== want.drive)
						note_mismatch($sformatf("drive_value got %0d want %0d",
							$signed(m_tdata), want.drive));
					if (m_tuser[0] !== want.sat)
						note_mismatch($sformatf("saturated got %b want %b",
							m_tuser[0], want.sat));
				end
			end
			if (in_sent) begin
				expected_drive_q.push_back(pid_tick(s_tdata));
				accepted_cnt++;
			end
			if (in_sent || (m_tvalid && m_tready)) begin
				stuck = 0;
			end else begin
				stuck++;
				if (stuck >= STUCK_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Tolerance edges, both limits, and a flag set and then released.
		program_loop(24'd1000, 24'h010000, 24'h000100, 24'h008000, 24'd10,
			24'd2000, -24'sd2000);
		offer(16'd1000);
		offer(16'd990);
		offer(16'd989);
		offer(16'd1010);
		offer(16'd1011);
		offer(16'd0);
		offer(16'hFFFF);
		offer(16'd0);
		offer(16'd0);
		offer(16'd0);
		offer(16'hFFFF);
		offer(16'hFFFF);
		offer(16'd1000);
		offer(16'd500);
		offer(16'd1500);
		settle();

		// Zero target clears the sum; crossed limits with extreme gains.
		program_loop(24'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'd0,
			-24'sd100, 24'd100);
		offer(16'd0);
		offer(16'hFFFF);
		offer(16'd1);
		offer(16'h8000);
		offer(16'd0);
		offer(16'hFFFF);
		settle();

		for (int ph = 0; ph < 18; ph++) begin
			if (ph == 6) begin
				in_idle = 67;
				out_idle = 31;
			end
			if (ph == 12) begin
				in_idle = 0;
				out_idle = 0;
			end
			if (ph == 2 || ph == 13)
				stall_req = 1'b1;
			if (ph == 4 || ph == 5)
				windup_phase(ph == 4);
			else
				random_phase();
			settle();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
